// ----- design/dlvs_pkg.sv -----
// Shared types and constants for the dual latching valve sequencer.
package dlvs_pkg;

   localparam int NUM_VALVES = 2;
   localparam int TIMER_BITS = 16;
   localparam int CHANGE_TIME_BITS = 16;
   localparam int CMP_BITS = (TIMER_BITS > CHANGE_TIME_BITS) ? TIMER_BITS : CHANGE_TIME_BITS;
   localparam logic [CHANGE_TIME_BITS-1:0] CHANGE_TIME_RESET = 16'd1000;

   typedef enum logic [2:0] {
      POS_UNKNOWN = 3'd0,
      POS_AT_A    = 3'd1,
      POS_AT_B    = 3'd2,
      POS_TO_A    = 3'd3,
      POS_TO_B    = 3'd4
   } pos_type;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_MOVE_A = 2'd1,
      FUNC_MOVE_B = 2'd2,
      FUNC_TOGGLE = 2'd3
   } func_type;

   typedef struct packed {
      func_type func;
      logic     valve_index;
   } req_type;

   typedef struct packed {
      pos_type first_valve_state;
      pos_type second_valve_state;
      logic    first_drive_a;
      logic    first_drive_b;
      logic    second_drive_a;
      logic    second_drive_b;
      logic    driver_awake;
      logic    any_moving;
   } rsp_type;

   // Per-valve update request, decoded once at the top level.
   typedef struct packed {
      logic     accept;
      logic     selected;
      func_type func;
   } valve_ctl_type;

endpackage

// ----- design/dlvs_valve.sv -----
// One valve: position and pulse timer registers with their update logic.
module dlvs_valve
   import dlvs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  valve_ctl_type               ctl,
   input  logic [CHANGE_TIME_BITS-1:0] change_time,
   output pos_type                     pos_next
);

   localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = '1;

   pos_type               pos_ff;
   pos_type               pos_in;
   logic [TIMER_BITS-1:0] elapsed_ff;
   logic [TIMER_BITS-1:0] elapsed_in;

   always_comb begin
      logic                  moving;
      logic [TIMER_BITS-1:0] count;
      pos_type               tgt_moving;
      pos_type               tgt_at;
      moving     = (pos_ff == POS_TO_A) || (pos_ff == POS_TO_B);
      count      = elapsed_ff;
      tgt_moving = POS_TO_A;
      tgt_at     = POS_AT_A;
      pos_in     = pos_ff;
      elapsed_in = elapsed_ff;
      if (ctl.func == FUNC_TICK) begin
         if (moving) begin
            if (elapsed_ff != ELAPSED_MAX) begin
               count = elapsed_ff + 1'b1;
            end
            elapsed_in = count;
            if (CMP_BITS'(count) >= CMP_BITS'(change_time)) begin
               pos_in = (pos_ff == POS_TO_A) ? POS_AT_A : POS_AT_B;
            end
         end
      end else if (ctl.selected) begin
         case (ctl.func)
            FUNC_MOVE_B: begin
               tgt_moving = POS_TO_B;
               tgt_at     = POS_AT_B;
            end
            FUNC_TOGGLE: begin
               // toggle heads away from A; from unknown or B it heads to A
               if ((pos_ff == POS_AT_A) || (pos_ff == POS_TO_A)) begin
                  tgt_moving = POS_TO_B;
                  tgt_at     = POS_AT_B;
               end
            end
            default: begin
               tgt_moving = POS_TO_A;
               tgt_at     = POS_AT_A;
            end
         endcase
         if ((pos_ff != tgt_moving) && (pos_ff != tgt_at)) begin
            pos_in     = tgt_moving;
            elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_UNKNOWN;
         elapsed_ff <= '0;
      end else if (ctl.accept) begin
         pos_ff     <= pos_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign pos_next = pos_in;

endmodule

// ----- design/dual_latching_valve_sequencer_unit.sv -----
// Top level of the dual latching valve sequencer: valves, driver line and result buffer.
//
// Usage: each transaction on the req_ channel is either a tick (one time unit passes
// for every moving valve) or a command (move to A, move to B, toggle) for the valve
// given by valve_index. Every request transaction yields exactly one rsp_ transaction
// carrying both valve states, the four coil drive lines, the driver wake line and the
// moving flag as they stand after that request.
// csr_wr_en with csr_wr_data sets the pulse length in ticks; write it only when idle.
// Each result is registered into the main entry, or the skid entry on a stall.
// Throughput is one request per cycle while the skid entry is empty; the valve update
// is a single pass of logic between the state registers and a two-entry result buffer.
// Reset puts both valves in the unknown state, clears the timers, puts the driver
// to sleep and sets the pulse length to 1000 ticks.
// When the receiver stalls, one further request is taken into the skid entry;
// req_ready then drops until the skid entry drains.
module dual_latching_valve_sequencer_unit
   import dlvs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  req_type                     req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsp_type                     rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [CHANGE_TIME_BITS-1:0] csr_wr_data
);

   logic [CHANGE_TIME_BITS-1:0] change_time_ff;
   logic                        driver_on_ff;
   logic                        driver_on_in;
   pos_type                     pos_next [NUM_VALVES];
   logic                        accept;
   logic                        pop;
   logic                        moving_in;
   pos_type                     s0;
   pos_type                     s1;
   rsp_type                     result_in;
   rsp_type                     main_ff;
   rsp_type                     skid_ff;
   logic                        main_valid_ff;
   logic                        skid_valid_ff;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = main_valid_ff && rsp_ready;

   for (genvar i = 0; i < NUM_VALVES; i++) begin : g_valve
      valve_ctl_type ctl;
      assign ctl.accept   = accept;
      assign ctl.selected = (int'(req_payload.valve_index) == i);
      assign ctl.func     = req_payload.func;
      dlvs_valve u_valve (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .change_time (change_time_ff),
         .pos_next    (pos_next[i])
      );
   end

   always_comb begin
      moving_in = 1'b0;
      for (int i = 0; i < NUM_VALVES; i++) begin
         moving_in = moving_in || (pos_next[i] == POS_TO_A) || (pos_next[i] == POS_TO_B);
      end
   end

   // the driver is awake exactly while some valve moves; a command that starts a move wakes it
   assign driver_on_in = moving_in;

   assign s0 = pos_next[0];
   if (NUM_VALVES > 1) begin : g_second
      assign s1 = pos_next[NUM_VALVES > 1 ? 1 : 0];
   end else begin : g_no_second
      assign s1 = POS_UNKNOWN;
   end

   always_comb begin
      result_in.first_valve_state  = s0;
      result_in.second_valve_state = s1;
      result_in.first_drive_a      = (s0 == POS_TO_A);
      result_in.first_drive_b      = (s0 == POS_TO_B);
      result_in.second_drive_a     = (s1 == POS_TO_A);
      result_in.second_drive_b     = (s1 == POS_TO_B);
      result_in.driver_awake       = driver_on_in;
      result_in.any_moving         = moving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         change_time_ff <= CHANGE_TIME_RESET;
         driver_on_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            change_time_ff <= csr_wr_data;
         end
         if (accept) begin
            driver_on_ff <= driver_on_in;
         end
      end
   end

   // two-entry result buffer: main entry faces the receiver, skid entry absorbs a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               main_valid_ff <= accept;
            end
         end else if (accept) begin
            if (main_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               main_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if (accept && (pop || !main_valid_ff)) begin
         main_ff <= result_in;
      end
      if (accept && main_valid_ff && !pop) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result while main entry is empty");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no result");

   a_driver_tracks_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.driver_awake == rsp_payload.any_moving))
      else $error("driver wake line differs from moving flag");

   a_state_tracks_driver: assert property (@(posedge clock) disable iff (reset)
      accept |=> (driver_on_ff == $past(moving_in)))
      else $error("driver register did not follow the valve states");

   a_coil_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.first_drive_a && rsp_payload.first_drive_b)
                 && !(rsp_payload.second_drive_a && rsp_payload.second_drive_b))
      else $error("coil driven toward both sides");

endmodule
